// ===== sv/tlvtcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlvtcc_pkg
// Shared types and constants for the TLV tag constraint checker: transaction
// payloads, operation and status codes, flag bit positions, table sizing.
// ----------------------------------------------------------------------------
package tlvtcc_pkg;

  // Table sizing and field widths
  localparam int MAX_ENTRIES = 32;
  localparam int TAG_BITS    = 32;
  localparam int LEN_BITS    = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int SEEN_W      = 8;
  localparam int CFG_W       = 6;

  // Flag bit positions
  localparam int FL_TEMPLATE = 0;
  localparam int FL_SEQUENCE = 1;
  localparam int FL_CHECK    = 2;
  localparam int FL_OPTIONAL = 3;
  localparam int FL_UNION    = 4;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_BEGIN  = 2'd1,
    OP_HEADER = 2'd2,
    OP_END    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNKNOWN  = 3'd1,
    ST_TPL_REP  = 3'd2,
    ST_MULTI    = 3'd3,
    ST_SIZE     = 3'd4,
    ST_MISSING  = 3'd5,
    ST_IGNORED  = 3'd6
  } status_t;

  // Input transaction payload
  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  entry_index;
    logic [31:0] tag_value;
    logic [15:0] length;
    logic [4:0]  flags;
    logic [15:0] min_len;
    logic [15:0] max_len;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic [2:0] status;
    logic       matched;
    logic [4:0] found_index;
    logic       message_failed;
  } out_item_t;

  // One tag table entry
  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [4:0]          flags;
    logic [LEN_BITS-1:0] min_len;
    logic [LEN_BITS-1:0] max_len;
  } entry_t;

  // Sequencer to storage control
  typedef struct packed {
    logic              tbl_we;
    logic [IDX_W-1:0]  tbl_waddr;
    logic              seen_we;
    logic [IDX_W-1:0]  seen_waddr;
    logic [SEEN_W-1:0] seen_wdata;
    logic              seen_clr;
    logic [IDX_W-1:0]  rd_addr;
  } store_ctl_t;

endpackage

// ===== sv/tlvtcc_store.sv =====
// ----------------------------------------------------------------------------
// tlvtcc_store
// Tag table memory and per-entry seen counters. One read address per cycle,
// read data registered. Seen counters carry valid bits so that a message
// start clears them all together.
// ----------------------------------------------------------------------------
module tlvtcc_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tlvtcc_pkg::store_ctl_t      ctl,
  input  tlvtcc_pkg::entry_t          tbl_wdata,
  output tlvtcc_pkg::entry_t          rd_entry,
  output logic [tlvtcc_pkg::SEEN_W-1:0] rd_count
);
  import tlvtcc_pkg::*;

  entry_t            tbl_mem [MAX_ENTRIES];
  logic [SEEN_W-1:0] seen_mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] seen_vld_r;
  logic [SEEN_W-1:0] seen_q_r;
  logic              seen_vld_q_r;

  // Table: write on load, registered read
  always_ff @(posedge clk) begin
    if (ctl.tbl_we) begin
      tbl_mem[ctl.tbl_waddr] <= tbl_wdata;
    end
    rd_entry <= tbl_mem[ctl.rd_addr];
  end

  // Seen counters: data array
  always_ff @(posedge clk) begin
    if (ctl.seen_we) begin
      seen_mem[ctl.seen_waddr] <= ctl.seen_wdata;
    end
    seen_q_r <= seen_mem[ctl.rd_addr];
  end

  // Seen counters: valid bits, cleared at reset and on message start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_vld_r   <= '0;
      seen_vld_q_r <= 1'b0;
    end else begin
      if (ctl.seen_clr) begin
        seen_vld_r <= '0;
      end else if (ctl.seen_we) begin
        seen_vld_r[ctl.seen_waddr] <= 1'b1;
      end
      seen_vld_q_r <= seen_vld_r[ctl.rd_addr];
    end
  end

  // An entry never counted in this message reads as zero
  assign rd_count = seen_vld_q_r ? seen_q_r : '0;

endmodule

// ===== sv/tlv_tag_constraint_checker_top.sv =====
// ----------------------------------------------------------------------------
// tlv_tag_constraint_checker_top
// Checks decoded BER TLV headers against a sorted tag table with a small
// sequencer around one shared table read port and tag compare.
// ----------------------------------------------------------------------------
// One transaction at a time. Load and begin need no table read, and their
// result is registered before it moves to the output register. A header is
// looked up by binary search over the entries in use (at most 6 probes for
// 32 entries); a header or an end after a failure is marked ignored without
// any table read. An end check walks the table one entry at a time in order,
// stopping at the first missing entry or after the last entry in use. Every
// search probe and scan step goes through the single registered read port of
// the tag table. The result sits in an output register, so the next
// transaction may be accepted while it waits to be taken; a second result
// stays inside the block until the first is taken. entries_in_use above 32
// is treated as 32; write it only while the block is idle.
// ----------------------------------------------------------------------------
module tlv_tag_constraint_checker_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [5:0]             cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tlvtcc_pkg::in_item_t   in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tlvtcc_pkg::out_item_t  out_data
);
  import tlvtcc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOOK = 7'b0000010,
    S_CMP  = 7'b0000100,
    S_UPD  = 7'b0001000,
    S_SCAN = 7'b0010000,
    S_SCHK = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    cfg_r;
  logic [CNT_W-1:0]    n_act;
  logic [CNT_W-1:0]    base_r, base_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [CNT_W-1:0]    half;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    probe_r, probe_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic [LEN_BITS-1:0] len_r, len_nxt;
  logic                failed_r, failed_nxt;
  out_item_t           res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;
  logic                in_acc;
  logic                tag_lt, tag_gt;
  logic                repeat_err, size_err, missing;
  store_ctl_t          ctl;
  entry_t              tbl_wdata;
  entry_t              rd_entry;
  logic [SEEN_W-1:0]   rd_count;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Active table size, clamped to the table depth
  assign n_act = (32'(cfg_r) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : CNT_W'(cfg_r);
  assign half  = n_r >> 1;

  // Shared tag compare and per-entry checks on the registered read data
  assign tag_lt     = tag_r < rd_entry.tag;
  assign tag_gt     = tag_r > rd_entry.tag;
  assign repeat_err = (rd_count != '0) &&
                      !(rd_entry.flags[FL_TEMPLATE] && rd_entry.flags[FL_SEQUENCE]);
  assign size_err   = rd_entry.flags[FL_CHECK] &&
                      ((len_r < rd_entry.min_len) || (len_r > rd_entry.max_len));
  assign missing    = !rd_entry.flags[FL_OPTIONAL] && !rd_entry.flags[FL_UNION] &&
                      (rd_count == '0);

  // Table write data comes straight from the load transaction
  assign tbl_wdata.tag     = in_data.tag_value[TAG_BITS-1:0];
  assign tbl_wdata.flags   = in_data.flags;
  assign tbl_wdata.min_len = LEN_BITS'(in_data.min_len);
  assign tbl_wdata.max_len = LEN_BITS'(in_data.max_len);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    probe_nxt     = probe_r;
    tag_nxt       = tag_r;
    len_nxt       = len_r;
    failed_nxt    = failed_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    ctl            = '0;
    ctl.tbl_waddr  = IDX_W'(in_data.entry_index);
    ctl.seen_waddr = probe_r;
    ctl.seen_wdata = (rd_count == {SEEN_W{1'b1}}) ? rd_count : rd_count + SEEN_W'(1);
    ctl.rd_addr    = probe_r;

    // Result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_nxt = '0;
          tag_nxt = in_data.tag_value[TAG_BITS-1:0];
          len_nxt = in_data.length[LEN_BITS-1:0];
          base_nxt = '0;
          n_nxt    = n_act;
          idx_nxt  = '0;
          state_nxt = S_DONE;
          unique case (op_t'(in_data.operation))
            OP_LOAD: begin
              ctl.tbl_we = (32'(in_data.entry_index) < MAX_ENTRIES);
              res_nxt.found_index = in_data.entry_index;
            end
            OP_BEGIN: begin
              ctl.seen_clr = 1'b1;
              failed_nxt   = 1'b0;
            end
            OP_HEADER: begin
              if (failed_r) res_nxt.status = ST_IGNORED;
              else          state_nxt      = S_LOOK;
            end
            OP_END: begin
              if (failed_r) res_nxt.status = ST_IGNORED;
              else          state_nxt      = S_SCAN;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      // Issue a probe at the middle of the remaining range
      S_LOOK: begin
        ctl.rd_addr = IDX_W'(base_r + half);
        probe_nxt   = IDX_W'(base_r + half);
        if (n_r == '0) begin
          res_nxt.status = ST_UNKNOWN;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_CMP;
        end
      end

      // Narrow the range or stop on a hit
      S_CMP: begin
        if (tag_lt) begin
          n_nxt     = half;
          state_nxt = S_LOOK;
        end else if (tag_gt) begin
          base_nxt  = CNT_W'(base_r + half + 1'b1);
          n_nxt     = CNT_W'(n_r - half - 1'b1);
          state_nxt = S_LOOK;
        end else begin
          state_nxt = S_UPD;
        end
      end

      // Repeat and size checks, count update
      S_UPD: begin
        res_nxt.matched     = 1'b1;
        res_nxt.found_index = 5'(probe_r);
        if (repeat_err) begin
          res_nxt.status = rd_entry.flags[FL_TEMPLATE] ? ST_TPL_REP : ST_MULTI;
          failed_nxt     = 1'b1;
        end else begin
          ctl.seen_we = 1'b1;
          if (size_err) begin
            res_nxt.status = ST_SIZE;
            failed_nxt     = 1'b1;
          end
        end
        state_nxt = S_DONE;
      end

      // End of message: walk entries in order
      S_SCAN: begin
        ctl.rd_addr = IDX_W'(idx_r);
        if (idx_r >= n_act) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCHK;
        end
      end

      S_SCHK: begin
        if (missing) begin
          res_nxt.status      = ST_MISSING;
          res_nxt.found_index = 5'(idx_r);
          failed_nxt          = 1'b1;
          state_nxt           = S_DONE;
        end else begin
          idx_nxt   = CNT_W'(idx_r + 1'b1);
          state_nxt = S_SCAN;
        end
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt                = res_r;
          out_data_nxt.message_failed = failed_r;
          out_valid_nxt               = 1'b1;
          state_nxt                   = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= '0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      failed_r    <= failed_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    probe_r    <= probe_nxt;
    tag_r      <= tag_nxt;
    len_r      <= len_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  tlvtcc_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .tbl_wdata (tbl_wdata),
    .rd_entry  (rd_entry),
    .rd_count  (rd_count)
  );

endmodule

// ===== sv/tlvtcc_checker.sv =====
// ----------------------------------------------------------------------------
// tlvtcc_checker
// Port-level checks for the TLV tag constraint checker, bound to the top.
// ----------------------------------------------------------------------------
module tlvtcc_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input tlvtcc_pkg::out_item_t out_data
);
  import tlvtcc_pkg::*;

  // A pending result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // The block works on one transaction at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a transaction while busy");

  // Any error or ignored status comes with the failure flag
  a_fail_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_TPL_REP || out_data.status == ST_MULTI ||
                  out_data.status == ST_SIZE || out_data.status == ST_MISSING ||
                  out_data.status == ST_IGNORED)
    |-> out_data.message_failed)
    else $error("error status without failure flag");

  // A match only comes with a per-entry header status
  a_match_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.matched
    |-> out_data.status != ST_UNKNOWN && out_data.status != ST_MISSING &&
        out_data.status != ST_IGNORED)
    else $error("matched flag with a non-header status");

  // Nothing pending right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind tlv_tag_constraint_checker_top tlvtcc_checker u_tlvtcc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
